FILE: rtl/stl_pkg.sv
// Shared types, codes and key-ordering function for the sorted table lookup.
`default_nettype none

package stl_pkg;

  // Payload widths
  localparam int unsigned ENTRY_IDX_W = 10;
  localparam int unsigned KEY_W       = 64;
  localparam int unsigned ID_W        = 11;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned COUNT_W    = 11;
  localparam int unsigned MODE_W     = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_MODE    = 1'b1;

  // Request commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Key comparison modes; the unused code behaves as signed 64-bit
  localparam logic [MODE_W-1:0] KEY_MODE_U8  = 2'd0;
  localparam logic [MODE_W-1:0] KEY_MODE_S32 = 2'd1;
  localparam logic [MODE_W-1:0] KEY_MODE_S64 = 2'd2;

  // Map a raw key to an unsigned value whose order matches the mode.
  function automatic logic [KEY_W-1:0] order_key(input logic [KEY_W-1:0] raw,
                                                 input logic [MODE_W-1:0] mode);
    logic [KEY_W-1:0] res;
    case (mode)
      KEY_MODE_U8:  res = {56'd0, raw[7:0]};
      KEY_MODE_S32: res = {32'd0, raw[31:0] ^ 32'h8000_0000};
      default:      res = raw ^ 64'h8000_0000_0000_0000;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/stl_if.sv
// Valid/ready channel interfaces for lookup requests and responses.
`default_nettype none

interface stl_req_if;
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic [stl_pkg::ENTRY_IDX_W-1:0]     entry_index;
  logic [stl_pkg::KEY_W-1:0]           key_bits;
  logic                                final_query;

  modport source (output valid, command, entry_index, key_bits, final_query,
                  input ready);
  modport sink   (input valid, command, entry_index, key_bits, final_query,
                  output ready);
endinterface

interface stl_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [stl_pkg::ID_W-1:0]    identifier;
  logic                        found;
  logic                        final_result;

  modport source (output valid, identifier, found, final_result, input ready);
  modport sink   (input valid, identifier, found, final_result, output ready);
endinterface

`default_nettype wire

FILE: rtl/sorted_table_id_lookup.sv
// Sorted key table with binary-search identifier lookup.
// Write request: stored at the edge where it is accepted, no response.
// Query request: each probe reads the table at the midpoint, then compares; at most
//   floor(log2(n))+1 probes, then the result waits for a free output register.
// One request at a time; the next is taken once the response sits in the output register.
// Reset (rst_ni low, async): idle, no response, entry_count 0, key_mode signed 64-bit.
`default_nettype none

module sorted_table_id_lookup #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  stl_req_if.sink                         req_i,
  stl_rsp_if.source                       rsp_o,
  input  wire                             cfg_we_i,
  input  wire [stl_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire [stl_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  // Address width of the table and width of the search bounds (0..TABLE_DEPTH)
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  // Sequencer states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_PROBE  = 2'd1;  // check bounds, read table at midpoint
  localparam logic [1:0] S_CMP    = 2'd2;  // compare read entry, narrow the range
  localparam logic [1:0] S_FINISH = 2'd3;  // hand result to the output register

  logic [1:0] state_q, state_d;

  // Configuration
  logic [stl_pkg::COUNT_W-1:0] entry_count_q;
  logic [stl_pkg::MODE_W-1:0]  key_mode_q;

  // Search datapath
  logic [CW-1:0]              low_q, low_d;
  logic [CW-1:0]              high_q, high_d;
  logic [CW-1:0]              mid_q;
  logic [CW-1:0]              mid_c;
  logic [CW:0]                mid_sum;
  logic [stl_pkg::KEY_W-1:0]  target_q;
  logic                       last_q;
  logic                       hit_q, hit_d;
  logic [CW-1:0]              count_sat;
  logic [stl_pkg::KEY_W-1:0]  probe_key;
  logic                       probe_eq;
  logic                       probe_gt;

  // Key table: no reset, contents undefined until written
  logic [stl_pkg::KEY_W-1:0]  key_table_q [TABLE_DEPTH];
  logic [stl_pkg::KEY_W-1:0]  rd_data_q;
  logic                       tbl_we;
  logic                       tbl_re;
  logic [AW-1:0]              wr_addr;

  // Output register
  logic                       rsp_valid_q, rsp_valid_d;
  logic                       rsp_load;
  logic [stl_pkg::ID_W-1:0]   rsp_ident_q;
  logic                       rsp_found_q;
  logic                       rsp_last_q;

  logic req_fire;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid & req_i.ready;

  // Writes beyond the table are dropped
  assign wr_addr = AW'(req_i.entry_index);
  assign tbl_we  = req_fire && (req_i.command == stl_pkg::CMD_WRITE) &&
                   (32'(req_i.entry_index) < TABLE_DEPTH);

  // Counts above the depth saturate
  assign count_sat = (32'(entry_count_q) > TABLE_DEPTH) ? CW'(TABLE_DEPTH)
                                                        : CW'(entry_count_q);

  assign mid_sum = {1'b0, low_q} + {1'b0, high_q};
  assign mid_c   = mid_sum[CW:1];
  assign tbl_re  = (state_q == S_PROBE) && (low_q != high_q);

  // The shared compare: one table entry against the stored target
  assign probe_key = stl_pkg::order_key(rd_data_q, key_mode_q);
  assign probe_eq  = (probe_key == target_q);
  assign probe_gt  = (probe_key > target_q);

  assign rsp_load = (state_q == S_FINISH) && (!rsp_valid_q || rsp_o.ready);

  // Config register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
      key_mode_q    <= stl_pkg::KEY_MODE_S64;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        stl_pkg::CFG_ENTRY_COUNT: entry_count_q <= cfg_data_i;
        stl_pkg::CFG_KEY_MODE:    key_mode_q    <= cfg_data_i[stl_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      key_table_q[wr_addr] <= req_i.key_bits;
    end
    if (tbl_re) begin
      rd_data_q <= key_table_q[mid_c[AW-1:0]];
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    low_d   = low_q;
    high_d  = high_q;
    hit_d   = hit_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_fire && (req_i.command == stl_pkg::CMD_QUERY)) begin
          low_d   = '0;
          high_d  = count_sat;
          hit_d   = 1'b0;
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        // Empty range: miss
        state_d = (low_q == high_q) ? S_FINISH : S_CMP;
      end
      S_CMP: begin
        if (probe_eq) begin
          hit_d   = 1'b1;
          state_d = S_FINISH;
        end else begin
          if (probe_gt) begin
            high_d = mid_q;
          end else begin
            low_d = mid_q + CW'(1);
          end
          state_d = S_PROBE;
        end
      end
      S_FINISH: begin
        if (rsp_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (rsp_load) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Search payload
  always_ff @(posedge clk_i) begin
    low_q  <= low_d;
    high_q <= high_d;
    hit_q  <= hit_d;
    if (tbl_re) begin
      mid_q <= mid_c;
    end
    if (req_fire) begin
      target_q <= stl_pkg::order_key(req_i.key_bits, key_mode_q);
      last_q   <= req_i.final_query;
    end
    if (rsp_load) begin
      rsp_ident_q <= hit_q ? stl_pkg::ID_W'({1'b0, mid_q} + {{CW{1'b0}}, 1'b1}) : '0;
      rsp_found_q <= hit_q;
      rsp_last_q  <= last_q;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.identifier   = rsp_ident_q;
  assign rsp_o.found        = rsp_found_q;
  assign rsp_o.final_result = rsp_last_q;

  // Checks
  a_miss_zero_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && !rsp_found_q |-> rsp_ident_q == '0)
    else $error("unrecognized response with non-zero identifier");

  a_bounds_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE) || (state_q == S_CMP) |-> (low_q <= high_q) &&
    (32'(high_q) <= TABLE_DEPTH))
    else $error("search bounds out of order");

  a_mid_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CMP |-> (mid_q >= low_q) && (mid_q < high_q))
    else $error("probe outside search range");

  a_range_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) && !probe_eq |=>
    ((high_q - low_q) < ($past(high_q) - $past(low_q))))
    else $error("search range did not narrow");

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) && !probe_eq |=> state_q == S_PROBE && !req_i.ready)
    else $error("sequencer left the search early");

endmodule

`default_nettype wire
